// ----- rtl/keyframe_spline_camera_path_defines.svh -----
// Assertion macros shared by the camera path RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef KEYFRAME_SPLINE_CAMERA_PATH_DEFINES_SVH
`define KEYFRAME_SPLINE_CAMERA_PATH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KSCP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kscp assertion failed");

// next-cycle implication, disabled in reset
`define KSCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kscp assertion failed");

`endif

// ----- rtl/kscp_pkg.sv -----
// Package for the keyframe spline camera path: sizes, codes, key record,
// controller states and the command/status structs. Depends on nothing.
`default_nettype none

package kscp_pkg;

  localparam int MAX_KEYS    = 256;
  localparam int ADDR_W      = $clog2(MAX_KEYS);
  localparam int CNT_W       = $clog2(MAX_KEYS + 1);
  localparam int KEY_TOTAL_W = 9;
  localparam int FRAC_W      = 17;            // 0..65536
  localparam int QUO_W       = 16;
  localparam int ACC_W       = 38;            // spline terms stay below 2^37
  localparam int PROD_W      = ACC_W + FRAC_W + 1;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_FEW  = 2'd2
  } stat_t;

  typedef struct packed {
    logic        [31:0] time_ms;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] pitch;
    logic        [15:0] yaw;
    logic        [15:0] roll;
  } key_t;

  // memory read address sources
  typedef enum logic [2:0] {
    RD_IDX_M1,
    RD_IDX_P1,
    RD_IDX,
    RD_K0,
    RD_K3
  } rd_sel_t;

  typedef enum logic {
    WR_MOVE,
    WR_NEW
  } wr_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_WR,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FETCH0,
    ST_FETCH1,
    ST_FETCH2,
    ST_FETCH3,
    ST_FETCH4,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SPL,
    ST_SPL_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load_req;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       idx_load_count;
    logic       idx_clear;
    logic       idx_dec;
    logic       idx_inc;
    logic       cnt_inc;
    logic       cnt_clear;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       div_start;
    logic       spl_start;
    logic       res_load;
    stat_t      res_status;
    logic       res_eval;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic few;
    logic idx_zero;
    logic rd_gt;
    logic walk_end;
    logic div_done;
    logic spl_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/kscp_if.sv -----
// Request and result channel interfaces of the camera path block.
// Depends on kscp_pkg for nothing but field widths written out here.
`default_nettype none

interface kscp_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic        [31:0] time_ms;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [15:0] pitch_in;
  logic        [15:0] yaw_in;
  logic        [15:0] roll_in;

  modport source (output valid, operation, time_ms, pos_x, pos_y, pos_z,
                  pitch_in, yaw_in, roll_in, input ready);
  modport sink   (input valid, operation, time_ms, pos_x, pos_y, pos_z,
                  pitch_in, yaw_in, roll_in, output ready);
endinterface

interface kscp_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] view_x;
  logic signed [31:0] view_y;
  logic signed [31:0] view_z;
  logic        [15:0] view_pitch;
  logic        [15:0] view_yaw;
  logic        [15:0] view_roll;
  logic        [8:0]  key_total;

  modport source (output valid, status, view_x, view_y, view_z, view_pitch,
                  view_yaw, view_roll, key_total, input ready);
  modport sink   (input valid, status, view_x, view_y, view_z, view_pitch,
                  view_yaw, view_roll, key_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/keyframe_spline_camera_path.sv -----
// Keyframe spline camera path top level: one request at a time.
// An add shifts each later key up a slot; an evaluate walks the segments, fetches four
// keys, divides the fraction unless it clamps, then runs the spline steps. Each request
// is loaded into the result register before the next is accepted; the key memory port
// and the multiplier are shared. Reset zeroes the count.
// Depends on kscp_pkg, kscp_if, kscp_ctrl and kscp_dp.
`default_nettype none

module keyframe_spline_camera_path (
  input  wire logic  clk,
  input  wire logic  rst,
  kscp_req_if.sink   req,
  kscp_rsp_if.source rsp
);
  import kscp_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  key_t     in_key;
  logic     req_ready;

  assign in_key.time_ms = req.time_ms;
  assign in_key.pos_x   = req.pos_x;
  assign in_key.pos_y   = req.pos_y;
  assign in_key.pos_z   = req.pos_z;
  assign in_key.pitch   = req.pitch_in;
  assign in_key.yaw     = req.yaw_in;
  assign in_key.roll    = req.roll_in;
  assign req.ready      = req_ready;

  kscp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kscp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (req.operation),
    .in_key     (in_key),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_x      (rsp.view_x),
    .out_y      (rsp.view_y),
    .out_z      (rsp.view_z),
    .out_pitch  (rsp.view_pitch),
    .out_yaw    (rsp.view_yaw),
    .out_roll   (rsp.view_roll),
    .out_total  (rsp.key_total)
  );

endmodule

`default_nettype wire

// ----- rtl/kscp_dp.sv -----
// Datapath: key memory, index/count, request and result registers,
// fraction divider and spline/angle sequencer. Depends on kscp_pkg.
`default_nettype none
`include "keyframe_spline_camera_path_defines.svh"

module kscp_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kscp_pkg::ctl_cmd_t  cmd,
  output kscp_pkg::dp_stat_t       stat,
  input  wire logic [1:0]          in_op,
  input  wire kscp_pkg::key_t      in_key,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic [15:0]              out_pitch,
  output logic [15:0]              out_yaw,
  output logic [15:0]              out_roll,
  output logic [kscp_pkg::KEY_TOTAL_W-1:0] out_total
);
  import kscp_pkg::*;

  // key memory
  key_t              mem [MAX_KEYS];
  key_t              rdata;
  logic [ADDR_W-1:0] rd_addr;
  key_t              wdata;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  op_t               req_op;
  key_t              req_key;
  key_t              kreg [4];

  // divider
  logic              div_busy;
  logic [4:0]        div_cnt;
  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic [QUO_W-1:0]  quo;
  logic [FRAC_W-1:0] frac;
  logic [32:0]       rem2;
  logic              rem_ge;

  // spline sequencer
  logic                     spl_busy;
  logic [3:0]               step;
  logic [1:0]               ax;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_sh;
  logic signed [ACC_W-1:0]  p0, p1, p2, p3, c_term, d_term, e_half;
  logic [15:0]              a1, a2, diff16;
  logic signed [31:0]       view_pos [3];
  logic [15:0]              view_ang [3];

  logic out_full;

  function automatic logic signed [31:0] pos_of(key_t k, logic [1:0] a);
    logic signed [31:0] r;
    case (a)
      2'd0:    r = k.pos_x;
      2'd1:    r = k.pos_y;
      default: r = k.pos_z;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] ang_of(key_t k, logic [1:0] a);
    logic [15:0] r;
    case (a)
      2'd0:    r = k.pitch;
      2'd1:    r = k.yaw;
      default: r = k.roll;
    endcase
    return r;
  endfunction

  // read address select
  always_comb begin
    logic [CNT_W:0] idx2;
    idx2 = {1'b0, idx} + (CNT_W+1)'(2);
    unique case (cmd.rd_sel)
      RD_IDX_M1: rd_addr = ADDR_W'(idx - CNT_W'(1));
      RD_IDX_P1: rd_addr = ADDR_W'(idx + CNT_W'(1));
      RD_IDX:    rd_addr = ADDR_W'(idx);
      RD_K0:     rd_addr = (idx == '0) ? ADDR_W'(idx) : ADDR_W'(idx - CNT_W'(1));
      RD_K3:     rd_addr = (idx2 < {1'b0, count}) ? ADDR_W'(idx2)
                                                  : ADDR_W'(idx + CNT_W'(1));
      default:   rd_addr = ADDR_W'(idx);
    endcase
  end

  assign wdata = (cmd.wr_sel == WR_MOVE) ? rdata : req_key;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[ADDR_W'(idx)] <= wdata;
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  // request capture and key registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op  <= op_t'(in_op);
      req_key <= in_key;
    end
    if (cmd.cap_en) kreg[cmd.cap_sel] <= rdata;
  end

  // index and key count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.cnt_clear)    count <= '0;
      else if (cmd.cnt_inc) count <= count + CNT_W'(1);
      if (cmd.idx_load_count) idx <= count;
      else if (cmd.idx_clear) idx <= '0;
      else if (cmd.idx_dec)   idx <= idx - CNT_W'(1);
      else if (cmd.idx_inc)   idx <= idx + CNT_W'(1);
    end
  end

  // fraction: one quotient bit per cycle
  assign rem2   = {rem, 1'b0};
  assign rem_ge = rem2 >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      if (kreg[2].time_ms <= kreg[1].time_ms || req_key.time_ms < kreg[1].time_ms) begin
        frac <= '0;
      end else if (req_key.time_ms >= kreg[2].time_ms) begin
        frac <= FRAC_ONE;
      end else begin
        rem      <= req_key.time_ms - kreg[1].time_ms;
        dvs      <= kreg[2].time_ms - kreg[1].time_ms;
        quo      <= '0;
        div_cnt  <= 5'(QUO_W);
        div_busy <= 1'b1;
      end
    end else if (div_busy) begin
      rem     <= rem_ge ? 32'(rem2 - {1'b0, dvs}) : rem2[31:0];
      quo     <= {quo[QUO_W-2:0], rem_ge};
      div_cnt <= div_cnt - 5'd1;
      if (div_cnt == 5'd1) begin
        div_busy <= 1'b0;
        frac     <= {1'b0, quo[QUO_W-2:0], rem_ge};
      end
    end
  end

  // per-axis control-point terms
  always_comb begin
    p0      = ACC_W'(pos_of(kreg[0], ax));
    p1      = ACC_W'(pos_of(kreg[1], ax));
    p2      = ACC_W'(pos_of(kreg[2], ax));
    p3      = ACC_W'(pos_of(kreg[3], ax));
    c_term  = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
    d_term  = ((p1 - p2) <<< 1) + (p1 - p2) + p3 - p0;
    a1      = ang_of(kreg[1], ax);
    a2      = ang_of(kreg[2], ax);
    diff16  = a2 - a1;
    prod_sh = ACC_W'(prod >>> 16);
    e_half  = acc >>> 1;
  end

  // one product register, fed every cycle
  always_ff @(posedge clk) begin
    prod <= acc * $signed({1'b0, frac});
  end

  // Horner steps: acc loads on steps 0, 2, 4, 6 and 7; the product settles in between
  always_ff @(posedge clk) begin
    if (rst) begin
      spl_busy <= 1'b0;
    end else if (cmd.spl_start) begin
      spl_busy <= 1'b1;
      step     <= 4'd0;
      ax       <= 2'd0;
    end else if (spl_busy) begin
      step <= (step == 4'd9) ? 4'd0 : step + 4'd1;
      case (step)
        4'd0: acc <= d_term;
        4'd2: acc <= prod_sh + c_term;
        4'd4: acc <= prod_sh + (p2 - p0);
        4'd6: acc <= prod_sh + (p1 <<< 1);
        4'd7: begin
          if (e_half > SAT_HI)      view_pos[ax] <= 32'(SAT_HI);
          else if (e_half < SAT_LO) view_pos[ax] <= 32'(SAT_LO);
          else                      view_pos[ax] <= 32'(e_half);
          acc <= ACC_W'($signed(diff16));
        end
        4'd9: begin
          view_ang[ax] <= a1 + prod_sh[15:0];
          ax           <= ax + 2'd1;
          if (ax == 2'd2) spl_busy <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.res_load) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= cmd.res_status;
      out_total  <= KEY_TOTAL_W'(count);
      out_x      <= cmd.res_eval ? view_pos[0] : '0;
      out_y      <= cmd.res_eval ? view_pos[1] : '0;
      out_z      <= cmd.res_eval ? view_pos[2] : '0;
      out_pitch  <= cmd.res_eval ? view_ang[0] : '0;
      out_yaw    <= cmd.res_eval ? view_ang[1] : '0;
      out_roll   <= cmd.res_eval ? view_ang[2] : '0;
    end
  end

  assign out_valid = out_full;

  // status to the controller
  always_comb begin
    stat.op       = req_op;
    stat.full     = count >= CNT_W'(MAX_KEYS);
    stat.few      = count < CNT_W'(2);
    stat.idx_zero = idx == '0;
    stat.rd_gt    = rdata.time_ms > req_key.time_ms;
    stat.walk_end = ({1'b0, idx} + (CNT_W+1)'(2)) >= {1'b0, count};
    stat.div_done = !div_busy;
    stat.spl_done = !spl_busy;
    stat.out_free = !out_full || out_ready;
  end

  `KSCP_ASSERT_NOW(a_wr_in_range, clk, rst, cmd.wr_en, idx < CNT_W'(MAX_KEYS))
  `KSCP_ASSERT_NOW(a_inc_not_full, clk, rst, cmd.cnt_inc, count < CNT_W'(MAX_KEYS))
  `KSCP_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.res_load, !out_full || out_ready)
  `KSCP_ASSERT_NEXT(a_spl_after_div, clk, rst, cmd.spl_start, !div_busy && spl_busy)

endmodule

`default_nettype wire

// ----- rtl/kscp_ctrl.sv -----
// Controller state machine: sequences insert, clear, segment walk, key
// fetch, divide and spline steps. Depends on kscp_pkg.
`default_nettype none

module kscp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire kscp_pkg::dp_stat_t stat,
  output kscp_pkg::ctl_cmd_t      cmd
);
  import kscp_pkg::*;

  state_t state, state_next;
  stat_t  res_code, res_code_next;
  logic   res_eval, res_eval_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res_code <= STAT_OK;
      res_eval <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      res_eval <= res_eval_next;
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    res_eval_next = res_eval;
    unique case (state)
      ST_IDLE:     if (req_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        res_code_next = STAT_OK;
        res_eval_next = 1'b0;
        unique case (stat.op)
          OP_ADD: begin
            if (stat.full) begin
              res_code_next = STAT_FULL;
              state_next    = ST_DONE;
            end else begin
              state_next = ST_INS_RD;
            end
          end
          OP_EVAL: begin
            if (stat.few) begin
              res_code_next = STAT_FEW;
              state_next    = ST_DONE;
            end else begin
              res_eval_next = 1'b1;
              state_next    = ST_WALK_RD;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_INS_RD:   state_next = stat.idx_zero ? ST_INS_WR : ST_INS_CHK;
      ST_INS_CHK:  state_next = stat.rd_gt ? ST_INS_RD : ST_INS_WR;
      ST_INS_WR:   state_next = ST_DONE;
      ST_WALK_RD:  state_next = stat.walk_end ? ST_FETCH0 : ST_WALK_CHK;
      ST_WALK_CHK: state_next = stat.rd_gt ? ST_FETCH0 : ST_WALK_RD;
      ST_FETCH0:   state_next = ST_FETCH1;
      ST_FETCH1:   state_next = ST_FETCH2;
      ST_FETCH2:   state_next = ST_FETCH3;
      ST_FETCH3:   state_next = ST_FETCH4;
      ST_FETCH4:   state_next = ST_DIV;
      ST_DIV:      state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (stat.div_done) state_next = ST_SPL;
      ST_SPL:      state_next = ST_SPL_WAIT;
      ST_SPL_WAIT: if (stat.spl_done) state_next = ST_DONE;
      ST_DONE:     if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_IDX;
    cmd.wr_sel     = WR_NEW;
    cmd.res_status = res_code;
    cmd.res_eval   = res_eval;
    req_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      ST_DECODE: begin
        cmd.idx_load_count = (stat.op == OP_ADD);
        cmd.idx_clear      = (stat.op == OP_EVAL);
        cmd.cnt_clear      = (stat.op == OP_CLEAR);
      end
      ST_INS_RD: begin
        cmd.rd_en  = !stat.idx_zero;
        cmd.rd_sel = RD_IDX_M1;
      end
      ST_INS_CHK: begin
        cmd.wr_en   = stat.rd_gt;
        cmd.wr_sel  = WR_MOVE;
        cmd.idx_dec = stat.rd_gt;
      end
      ST_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_WALK_RD: begin
        cmd.rd_en  = !stat.walk_end;
        cmd.rd_sel = RD_IDX_P1;
      end
      ST_WALK_CHK: cmd.idx_inc = !stat.rd_gt;
      ST_FETCH0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_K0;
      end
      ST_FETCH1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_IDX;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd0;
      end
      ST_FETCH2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_IDX_P1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd1;
      end
      ST_FETCH3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_K3;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd2;
      end
      ST_FETCH4: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd3;
      end
      ST_DIV:      cmd.div_start = 1'b1;
      ST_DIV_WAIT: ;
      ST_SPL:      cmd.spl_start = 1'b1;
      ST_SPL_WAIT: ;
      ST_DONE:     cmd.res_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- test/kscp_checker.sv -----
// Checker for the keyframe spline camera path: watches both channels, predicts
// each result from its own copy of the key table and compares field by field.
// Depends on kscp_pkg and the kscp_req_if / kscp_rsp_if interfaces.
`timescale 1ns / 100ps
`default_nettype none

module kscp_checker (
  input  wire logic clk,
  input  wire logic rst,
  kscp_req_if       req,
  kscp_rsp_if       rsp,
  output int        fail_count,
  output int        pending
);
  import kscp_pkg::*;

  typedef struct packed {
    stat_t              status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [15:0] pitch;
    logic        [15:0] yaw;
    logic        [15:0] roll;
    logic        [8:0]  total;
  } view_t;

  key_t  keys [MAX_KEYS];
  int    num_keys;
  view_t view_q[$];

  // Catmull-Rom position, Q16.16 control points, Q1.16 fraction
  function automatic logic signed [31:0] path_pos(longint p0, longint p1, longint p2,
                                                  longint p3, longint t);
    longint c, d, a, b, e;
    c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    d = -p0 + 3 * p1 - 3 * p2 + p3;
    a = ((d * t) >>> 16) + c;
    b = ((a * t) >>> 16) + (p2 - p0);
    e = ((b * t) >>> 16) + 2 * p1;
    e = e >>> 1;
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    return e[31:0];
  endfunction

  // shortest-arc lerp; a half turn runs backwards
  function automatic logic [15:0] arc_lerp(logic [15:0] a, logic [15:0] b, longint t);
    logic [15:0] raw;
    longint      diff, r;
    raw  = b - a;
    diff = longint'($signed(raw));
    r    = longint'(a) + ((diff * t) >>> 16);
    return r[15:0];
  endfunction

  function automatic view_t camera_view(logic [1:0] op, logic [31:0] now, key_t k);
    view_t  v;
    int     i, i0, i3;
    longint t;
    key_t   k0, k1, k2, k3;
    v = '0;
    v.status = STAT_OK;
    case (op)
      OP_ADD: begin
        if (num_keys >= MAX_KEYS) begin
          v.status = STAT_FULL;
        end else begin
          i = num_keys;
          while (i > 0 && keys[i-1].time_ms > now) begin
            keys[i] = keys[i-1];
            i--;
          end
          keys[i] = k;
          num_keys++;
        end
      end
      OP_CLEAR: num_keys = 0;
      OP_EVAL: begin
        if (num_keys < 2) begin
          v.status = STAT_FEW;
        end else begin
          i = 0;
          while (i < num_keys - 2 && keys[i+1].time_ms <= now) i++;
          i0 = (i > 0) ? i - 1 : i;
          i3 = (i + 2 < num_keys) ? i + 2 : i + 1;
          k0 = keys[i0]; k1 = keys[i]; k2 = keys[i+1]; k3 = keys[i3];
          if (k2.time_ms <= k1.time_ms || now < k1.time_ms) t = 0;
          else if (now >= k2.time_ms) t = 65536;
          else t = ((longint'(now - k1.time_ms)) << 16) / longint'(k2.time_ms - k1.time_ms);
          v.x = path_pos(k0.pos_x, k1.pos_x, k2.pos_x, k3.pos_x, t);
          v.y = path_pos(k0.pos_y, k1.pos_y, k2.pos_y, k3.pos_y, t);
          v.z = path_pos(k0.pos_z, k1.pos_z, k2.pos_z, k3.pos_z, t);
          v.pitch = arc_lerp(k1.pitch, k2.pitch, t);
          v.yaw   = arc_lerp(k1.yaw, k2.yaw, t);
          v.roll  = arc_lerp(k1.roll, k2.roll, t);
        end
      end
      default: ;
    endcase
    v.total = num_keys[8:0];
    return v;
  endfunction

  // predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    key_t  k;
    view_t got, want;
    if (rst) begin
      num_keys   = 0;
      fail_count = 0;
      view_q.delete();
      pending    = 0;
    end else begin
      if (req.valid && req.ready) begin
        k = '{req.time_ms, req.pos_x, req.pos_y, req.pos_z,
              req.pitch_in, req.yaw_in, req.roll_in};
        view_q.push_back(camera_view(req.operation, req.time_ms, k));
      end
      if (rsp.valid && rsp.ready) begin
        got = '{stat_t'(rsp.status), rsp.view_x, rsp.view_y, rsp.view_z,
                rsp.view_pitch, rsp.view_yaw, rsp.view_roll, rsp.key_total};
        if (view_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = view_q.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status); fail_count++;
          end
          if (got.x !== want.x) begin
            $error("view_x expected %0d got %0d", want.x, got.x); fail_count++;
          end
          if (got.y !== want.y) begin
            $error("view_y expected %0d got %0d", want.y, got.y); fail_count++;
          end
          if (got.z !== want.z) begin
            $error("view_z expected %0d got %0d", want.z, got.z); fail_count++;
          end
          if (got.pitch !== want.pitch) begin
            $error("view_pitch expected %0d got %0d", want.pitch, got.pitch); fail_count++;
          end
          if (got.yaw !== want.yaw) begin
            $error("view_yaw expected %0d got %0d", want.yaw, got.yaw); fail_count++;
          end
          if (got.roll !== want.roll) begin
            $error("view_roll expected %0d got %0d", want.roll, got.roll); fail_count++;
          end
          if (got.total !== want.total) begin
            $error("key_total expected %0d got %0d", want.total, got.total); fail_count++;
          end
        end
      end
      pending = view_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/keyframe_spline_camera_path_tb.sv -----
// Testbench top for keyframe_spline_camera_path: drives requests with random
// gaps and result stalls; kscp_checker does prediction and comparison.
// Depends on kscp_pkg, kscp_if, the block and test/kscp_checker.sv.
`timescale 1ns / 100ps
`default_nettype none

module keyframe_spline_camera_path_tb;
  import kscp_pkg::*;

  localparam int NUM_RANDOM = 1450;
  localparam int CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending;
  int   cycles = 0;
  int   sent = 0;

  kscp_req_if req ();
  kscp_rsp_if rsp ();

  keyframe_spline_camera_path dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  kscp_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                    .fail_count(fail_count), .pending(pending));

  always #10 clk = ~clk;

  // no-idle stretches: every fourth block of 100 requests runs at full rate
  function automatic int gap();
    return ((sent / 100) % 4 == 0) ? 0 : $urandom_range(0, 5);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = gap();
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
    end
  end

  task automatic send(op_t op, logic [31:0] tm, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z, logic [15:0] p, logic [15:0] yw, logic [15:0] r);
    int n;
    n = gap();
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.time_ms   <= tm;
    req.pos_x     <= x;
    req.pos_y     <= y;
    req.pos_z     <= z;
    req.pitch_in  <= p;
    req.yaw_in    <= yw;
    req.roll_in   <= r;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  function automatic logic [31:0] rand_pos();
    int s;
    s = $urandom_range(0, 9);
    if (s < 6) return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
    if (s < 8) return $urandom;
    return s[0] ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  function automatic logic [31:0] rand_time();
    return ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 20) * 100) : $urandom;
  endfunction

  task automatic add_rand(logic [31:0] tm);
    send(OP_ADD, tm, rand_pos(), rand_pos(), rand_pos(),
         16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic query(op_t op, logic [31:0] tm);
    send(op, tm, $urandom, $urandom, $urandom,
         16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int sel;
    req.valid     = 1'b0;
    req.operation = OP_NONE;
    req.time_ms   = '0;
    req.pos_x     = '0;
    req.pos_y     = '0;
    req.pos_z     = '0;
    req.pitch_in  = '0;
    req.yaw_in    = '0;
    req.roll_in   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: too few keys, extremes, equal times, half turn, clamps
    query(OP_EVAL, 32'd0);
    send(OP_ADD, 32'd100, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 16'd0, 16'hffff, 16'd100);
    query(OP_EVAL, 32'd100);
    send(OP_ADD, 32'd100, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
         16'd32768, 16'h7fff, 16'd60000);
    query(OP_EVAL, 32'd100);
    send(OP_ADD, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
         16'hffff, 16'd0, 16'd1);
    send(OP_ADD, 32'd1000, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678,
         16'd32768, 16'd32768, 16'd32767);
    send(OP_ADD, 32'd50, 32'd65536, 32'hffff_0000, 32'd0, 16'd0, 16'd32768, 16'd0);
    query(OP_EVAL, 32'd0);
    query(OP_EVAL, 32'd75);
    query(OP_EVAL, 32'd100);
    query(OP_EVAL, 32'd550);
    query(OP_EVAL, 32'd999);
    query(OP_EVAL, 32'h8000_0000);
    query(OP_EVAL, 32'hffff_ffff);
    query(OP_NONE, 32'd500);
    query(OP_CLEAR, 32'd0);
    query(OP_EVAL, 32'd500);

    // random: mostly adds and evaluations over a growing table
    for (int n = 0; n < NUM_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) add_rand(rand_time());
      else if (sel < 93) query(OP_EVAL, ($urandom_range(0, 1) != 0) ?
                               32'($urandom_range(0, 2100)) : $urandom);
      else if (sel < 97) query(OP_CLEAR, $urandom);
      else query(OP_NONE, $urandom);
    end

    // fill the table, overflow it, evaluate the full table
    query(OP_CLEAR, 32'd0);
    for (int n = 0; n <= MAX_KEYS; n++) add_rand(rand_time());
    for (int n = 0; n < 20; n++) query(OP_EVAL, ($urandom_range(0, 1) != 0) ?
                                       32'($urandom_range(0, 2100)) : $urandom);
    add_rand(rand_time());

    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
